// File: design/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types, constants and the byte-class lookup function for the UTF-8 DFA decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CLASS_W  = 4;
    localparam int unsigned STATE_W  = 4;
    localparam int unsigned CODE_W   = 21;
    localparam int unsigned UNIT_W   = 16;
    localparam int unsigned N_STATES = 9;
    localparam int unsigned N_CLASS  = 16;

    // DFA states: accept, reject, and the mid-sequence states
    typedef enum logic [STATE_W-1:0] {
        ST_ACCEPT = 4'd0,
        ST_REJECT = 4'd1,
        ST_MID2   = 4'd2,
        ST_MID3   = 4'd3,
        ST_MID4   = 4'd4,
        ST_MID5   = 4'd5,
        ST_MID6   = 4'd6,
        ST_MID7   = 4'd7,
        ST_MID8   = 4'd8
    } dfa_state_t;

    // Result of one decode step, handed from the step logic to the top level
    typedef struct packed {
        dfa_state_t        state;
        logic [CODE_W-1:0] code;
        logic              emit;
    } step_res_t;

    // Transition ROM, indexed by state then by byte class
    localparam logic [STATE_W-1:0] NEXT_STATE [N_STATES][N_CLASS] = '{
        '{4'd0,4'd1,4'd2,4'd3,4'd5,4'd8,4'd7,4'd1,4'd1,4'd1,4'd4,4'd6,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd0,4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1}
    };

    // Map a raw byte to its character class
    function automatic logic [CLASS_W-1:0] byte_class(input logic [BYTE_W-1:0] b);
        logic [CLASS_W-1:0] cls;
        priority if (b <= 8'h7F) begin
            cls = 4'd0;
        end else if (b <= 8'h8F) begin
            cls = 4'd1;
        end else if (b <= 8'h9F) begin
            cls = 4'd9;
        end else if (b <= 8'hBF) begin
            cls = 4'd7;
        end else if (b <= 8'hC1) begin
            cls = 4'd8;
        end else if (b <= 8'hDF) begin
            cls = 4'd2;
        end else if (b == 8'hE0) begin
            cls = 4'd10;
        end else if (b == 8'hED) begin
            cls = 4'd4;
        end else if (b <= 8'hEF) begin
            cls = 4'd3;
        end else if (b == 8'hF0) begin
            cls = 4'd11;
        end else if (b <= 8'hF3) begin
            cls = 4'd6;
        end else if (b == 8'hF4) begin
            cls = 4'd5;
        end else begin
            cls = 4'd8;
        end
        return cls;
    endfunction

endpackage

// File: design/utf8_dfa_decoder.sv
// A code unit appears on m_ in the cycle after its final byte is accepted.
// Throughput: one byte per cycle while s_ready is high; the DFA state and code registers close the loop.
// A byte is taken whenever the result register is empty or being drained.
// Reset (aresetn low, synchronous) returns the DFA to accept, clears the
// partial code point and empties the result register.
// ----------------------------------------------------------------------------
// utf8_dfa_decoder
// Streaming UTF-8 decoder that emits 16-bit code units.
// ----------------------------------------------------------------------------
module utf8_dfa_decoder import u8d_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [BYTE_W-1:0]  s_text_byte,
    input  logic               s_start_of_text,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [UNIT_W-1:0]  m_code_unit
);

    dfa_state_t          state_reg;
    logic [CODE_W-1:0]   code_reg;
    logic                m_valid_reg;
    logic                m_valid_next;
    logic [UNIT_W-1:0]   unit_reg;
    logic                in_fire;
    step_res_t           step;

    u8d_step u_step (
        .text_byte     (s_text_byte),
        .start_of_text (s_start_of_text),
        .state_cur     (state_reg),
        .code_cur      (code_reg),
        .res           (step)
    );

    // Accept a word when the result register is free or drains this cycle
    assign s_ready = !m_valid_reg || m_ready;
    assign in_fire = s_valid && s_ready;

    // Result register occupancy
    always_comb begin
        if (in_fire) begin
            m_valid_next = step.emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Advance DFA state and hold result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACCEPT;
            code_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (in_fire) begin
                state_reg <= step.state;
                code_reg  <= step.code;
            end
        end
    end

    // Capture the code unit payload
    always_ff @(posedge aclk) begin
        if (in_fire && step.emit) begin
            unit_reg <= step.code[UNIT_W-1:0];
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_code_unit = unit_reg;

endmodule

// File: design/u8d_step.sv
// ----------------------------------------------------------------------------
// u8d_step
// One DFA step: classify the byte, look up the next state, assemble the
// code point and flag a completed code unit.
// ----------------------------------------------------------------------------
module u8d_step import u8d_pkg::*; (
    input  logic [BYTE_W-1:0]  text_byte,
    input  logic               start_of_text,
    input  dfa_state_t         state_cur,
    input  logic [CODE_W-1:0]  code_cur,
    output step_res_t          res
);

    logic [CLASS_W-1:0]  cls;
    dfa_state_t          state_eff;
    dfa_state_t          state_nxt;
    logic [CODE_W-1:0]   code_nxt;

    // Apply start flag, fold unreachable codes into reject
    always_comb begin
        cls = byte_class(text_byte);
        if (start_of_text) begin
            state_eff = ST_ACCEPT;
        end else if (state_cur > ST_MID8) begin
            state_eff = ST_REJECT;
        end else begin
            state_eff = state_cur;
        end
    end

    // Next state from the transition ROM
    always_comb begin
        state_nxt = dfa_state_t'(NEXT_STATE[state_eff][cls]);
    end

    // Load lead-byte payload bits or shift in six continuation bits
    always_comb begin
        if (state_eff == ST_ACCEPT) begin
            code_nxt = {{(CODE_W-BYTE_W){1'b0}}, (8'hFF >> cls) & text_byte};
        end else begin
            code_nxt = {code_cur[CODE_W-7:0], text_byte[5:0]};
        end
    end

    // Emit only a complete code point that fits in one code unit
    always_comb begin
        res.state = state_nxt;
        res.code  = code_nxt;
        res.emit  = (state_nxt == ST_ACCEPT) && (code_nxt[CODE_W-1:UNIT_W] == '0);
    end

endmodule

// File: design/u8d_checker.sv
// ----------------------------------------------------------------------------
// u8d_checker
// Port-level checks for the UTF-8 DFA decoder, bound to the top level.
// ----------------------------------------------------------------------------
module u8d_checker import u8d_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [BYTE_W-1:0]  s_text_byte,
    input logic               s_start_of_text,
    input logic               m_valid,
    input logic               m_ready,
    input logic [UNIT_W-1:0]  m_code_unit
);

    // Stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_code_unit))
        else $error("result word changed while stalled");

    // Reset empties the result register
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Empty result register never blocks input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // Draining result register frees input in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |-> s_ready)
        else $error("input stalled while result drains");

    // ASCII word at start of text decodes to itself in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_start_of_text && !s_text_byte[7]
        |=> m_valid && (m_code_unit == {{(UNIT_W-BYTE_W){1'b0}}, $past(s_text_byte)}))
        else $error("ASCII word not passed through");

endmodule

bind utf8_dfa_decoder u8d_checker u_u8d_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_text_byte     (s_text_byte),
    .s_start_of_text (s_start_of_text),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_code_unit     (m_code_unit)
);
